/* hw/rtl/ubdc_pkg.sv */
// ----------------------------------------------------------------------------
// ubdc_pkg
// Shared types, widths and constants of the UART baud divisor calculator.
// ----------------------------------------------------------------------------
package ubdc_pkg;

   localparam int CLOCK_W     = 32;
   localparam int BAUD_W      = 32;
   localparam int FRAC_BITS   = 16;
   localparam int DIVIDEND_W  = CLOCK_W + FRAC_BITS;
   localparam int QUOT_W      = DIVIDEND_W;
   localparam int REM_W       = BAUD_W + 1;
   localparam int STEP_W      = $clog2(DIVIDEND_W);
   localparam int INT_W       = QUOT_W - FRAC_BITS;

   localparam int PRESC_W     = 16;
   localparam int FIRST_W     = 4;
   localparam int SECOND_W    = 8;
   localparam int STATUS_W    = 2;

   localparam logic [CLOCK_W-1:0] CLOCK_RESET   = 32'd3000000;
   localparam logic [INT_W-1:0]   OS_THRESHOLD  = 32'd16;
   localparam logic [PRESC_W-1:0] PRESCALER_MAX = 16'hFFFF;

   localparam int FRAC_ENTRIES = 36;

   localparam logic [FRAC_BITS-1:0] FRAC_THRESHOLD [FRAC_ENTRIES] = '{
      16'd0,     16'd3466,  16'd4685,  16'd5472,  16'd6560,  16'd8205,
      16'd9371,  16'd10944, 16'd14070, 16'd14575, 16'd16403, 16'd19660,
      16'd21856, 16'd23429, 16'd24595, 16'd26234, 16'd28088, 16'd28691,
      16'd32781, 16'd37453, 16'd39341, 16'd40986, 16'd42152, 16'd43692,
      16'd45881, 16'd46838, 16'd49171, 16'd51517, 16'd52455, 16'd54611,
      16'd55469, 16'd56177, 16'd57350, 16'd59008, 16'd60096, 16'd60869
   };

   localparam logic [SECOND_W-1:0] FRAC_PATTERN [FRAC_ENTRIES] = '{
      8'h00, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10,
      8'h20, 8'h11, 8'h21, 8'h22, 8'h44, 8'h25,
      8'h49, 8'h4A, 8'h52, 8'h92, 8'h53, 8'h55,
      8'hAA, 8'h6B, 8'hAD, 8'hB5, 8'hB6, 8'hD6,
      8'hB7, 8'hBB, 8'hDD, 8'hED, 8'hEE, 8'hBF,
      8'hDF, 8'hEF, 8'hF7, 8'hFB, 8'hFD, 8'hFE
   };

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_BAUD_ZERO = 2'd1,
      STATUS_SATURATED = 2'd2
   } ubdc_status_type;

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } ubdc_state_type;

   typedef struct packed {
      logic start;
   } ubdc_div_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } ubdc_div_stat_type;

   typedef struct packed {
      logic [PRESC_W-1:0]  prescaler;
      logic [FIRST_W-1:0]  first_modulation;
      logic                oversample_on;
      logic [SECOND_W-1:0] second_modulation;
      ubdc_status_type     status;
   } ubdc_result_type;

   function automatic logic [SECOND_W-1:0] pick_pattern(input logic [FRAC_BITS-1:0] frac);
      logic [SECOND_W-1:0] sel;
      sel = FRAC_PATTERN[0];
      for (int i = 0; i < FRAC_ENTRIES; i++) begin
         if (FRAC_THRESHOLD[i] <= frac) begin
            sel = FRAC_PATTERN[i];
         end
      end
      return sel;
   endfunction

endpackage

/* hw/rtl/ubdc_ifs.sv */
// ----------------------------------------------------------------------------
// ubdc_ifs
// Valid/ready channels of the baud divisor calculator: request, response
// and configuration write.
// ----------------------------------------------------------------------------
interface ubdc_req_if;
   logic                       valid;
   logic                       ready;
   logic [ubdc_pkg::BAUD_W-1:0] baud_rate;

   modport source (output valid, output baud_rate, input ready);
   modport sink   (input valid, input baud_rate, output ready);
endinterface

interface ubdc_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [ubdc_pkg::PRESC_W-1:0]   prescaler;
   logic [ubdc_pkg::FIRST_W-1:0]   first_modulation;
   logic                           oversample_on;
   logic [ubdc_pkg::SECOND_W-1:0]  second_modulation;
   logic [ubdc_pkg::STATUS_W-1:0]  status;

   modport source (output valid, output prescaler, output first_modulation,
                   output oversample_on, output second_modulation, output status,
                   input ready);
   modport sink   (input valid, input prescaler, input first_modulation,
                   input oversample_on, input second_modulation, input status,
                   output ready);
endinterface

interface ubdc_csr_if;
   logic                         valid;
   logic                         ready;
   logic [ubdc_pkg::CLOCK_W-1:0] source_clock_hz;

   modport source (output valid, output source_clock_hz, input ready);
   modport sink   (input valid, input source_clock_hz, output ready);
endinterface

/* hw/rtl/ubdc_divider.sv */
// ----------------------------------------------------------------------------
// ubdc_divider
// Restoring divider: (clock << 16) / baud, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ubdc_divider (
   input  logic                             clock,
   input  logic                             reset,
   input  ubdc_pkg::ubdc_div_ctrl_type      ctrl,
   input  logic [ubdc_pkg::CLOCK_W-1:0]     clock_hz,
   input  logic [ubdc_pkg::BAUD_W-1:0]      divisor,
   output ubdc_pkg::ubdc_div_stat_type      stat,
   output logic [ubdc_pkg::QUOT_W-1:0]      quotient
);
   import ubdc_pkg::*;

   logic [CLOCK_W-1:0] dividend_ff, dividend_in;
   logic [BAUD_W-1:0]  divisor_ff, divisor_in;
   logic [REM_W-1:0]   rem_ff, rem_in;
   logic [QUOT_W-1:0]  quo_ff, quo_in;
   logic [STEP_W-1:0]  count_ff, count_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;

   logic [REM_W-1:0]   shifted;
   logic [REM_W:0]     trial;
   logic               fits;

   always_comb begin
      shifted = {rem_ff[BAUD_W-1:0], dividend_ff[CLOCK_W-1]};
      trial   = {1'b0, shifted} - {2'b00, divisor_ff};
      fits    = ~trial[REM_W];

      dividend_in = dividend_ff;
      divisor_in  = divisor_ff;
      rem_in      = rem_ff;
      quo_in      = quo_ff;
      count_in    = count_ff;
      busy_in     = busy_ff;
      done_in     = done_ff;

      if (ctrl.start) begin
         dividend_in = clock_hz;
         divisor_in  = divisor;
         rem_in      = '0;
         count_in    = '0;
         busy_in     = 1'b1;
         done_in     = 1'b0;
      end else if (busy_ff) begin
         dividend_in = {dividend_ff[CLOCK_W-2:0], 1'b0};
         rem_in      = fits ? trial[REM_W-1:0] : shifted;
         quo_in      = {quo_ff[QUOT_W-2:0], fits};
         count_in    = count_ff + 1'b1;
         if (count_ff == STEP_W'(DIVIDEND_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      dividend_ff <= dividend_in;
      divisor_ff  <= divisor_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = quo_ff;

endmodule

/* hw/rtl/ubdc_format.sv */
// ----------------------------------------------------------------------------
// ubdc_format
// Splits the 32.16 ratio into prescaler, modulation fields and status.
// ----------------------------------------------------------------------------
module ubdc_format (
   input  logic [ubdc_pkg::QUOT_W-1:0]  quotient,
   input  logic                         baud_zero,
   output ubdc_pkg::ubdc_result_type    result
);
   import ubdc_pkg::*;

   logic [INT_W-1:0]     n_int;
   logic [FRAC_BITS-1:0] frac;
   logic                 os;
   logic [INT_W-1:0]     presc_wide;
   logic                 sat;

   always_comb begin
      n_int      = quotient[QUOT_W-1:FRAC_BITS];
      frac       = quotient[FRAC_BITS-1:0];
      os         = n_int > OS_THRESHOLD;
      presc_wide = os ? (n_int >> 4) : n_int;
      sat        = presc_wide > INT_W'(PRESCALER_MAX);

      if (baud_zero) begin
         result.prescaler         = '0;
         result.first_modulation  = '0;
         result.oversample_on     = 1'b0;
         result.second_modulation = '0;
         result.status            = STATUS_BAUD_ZERO;
      end else begin
         result.prescaler         = sat ? PRESCALER_MAX : presc_wide[PRESC_W-1:0];
         result.first_modulation  = os ? n_int[FIRST_W-1:0] : '0;
         result.oversample_on     = os;
         result.second_modulation = pick_pattern(frac);
         result.status            = sat ? STATUS_SATURATED : STATUS_OK;
      end
   end

endmodule

/* hw/rtl/uart_baud_divisor_calc.sv */
// ----------------------------------------------------------------------------
// uart_baud_divisor_calc
// UART baud divisor calculator with fractional modulation selection.
//
// Channels: csr_bus writes the source clock frequency (always ready, reset
// value 3000000 Hz); write it only while no request is in flight. req_bus
// carries a requested baud rate; rsp_bus returns prescaler, first and
// second modulation, oversampling flag and status (0 ok, 1 zero baud rate,
// 2 prescaler saturated).
// The response is valid once the divider has finished and the formatted
// result is loaded into the output register. The restoring divider produces
// one quotient bit per cycle over its 48 steps; req_bus.ready is low while
// the divider runs.
// Reset clears the sequencer, the divider control and the response valid.
// A stalled response stays in its output register; a new request is taken
// meanwhile, and its result waits in the divider until the register frees.
// ----------------------------------------------------------------------------
module uart_baud_divisor_calc (
   input  logic       clock,
   input  logic       reset,
   ubdc_csr_if.sink   csr_bus,
   ubdc_req_if.sink   req_bus,
   ubdc_rsp_if.source rsp_bus
);
   import ubdc_pkg::*;

   ubdc_state_type    state_ff, state_in;
   logic [CLOCK_W-1:0] clock_hz_ff, clock_hz_in;
   logic              baud_zero_ff, baud_zero_in;
   logic              rsp_valid_ff, rsp_valid_in;
   ubdc_result_type   result_ff, result_in;

   ubdc_div_ctrl_type div_ctrl;
   ubdc_div_stat_type div_stat;
   logic [QUOT_W-1:0] quotient;
   ubdc_result_type   formatted;

   logic              accept;
   logic              out_free;
   logic              load;

   ubdc_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (div_ctrl),
      .clock_hz (clock_hz_ff),
      .divisor  (req_bus.baud_rate),
      .stat     (div_stat),
      .quotient (quotient)
   );

   ubdc_format u_format (
      .quotient  (quotient),
      .baud_zero (baud_zero_ff),
      .result    (formatted)
   );

   assign csr_bus.ready = 1'b1;

   always_comb begin
      accept         = req_bus.valid && (state_ff == ST_IDLE);
      out_free       = !rsp_valid_ff || rsp_bus.ready;
      load           = 1'b0;
      div_ctrl.start = accept;
      state_in       = state_ff;
      baud_zero_in   = baud_zero_ff;
      result_in      = result_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               baud_zero_in = (req_bus.baud_rate == '0);
               state_in     = ST_RUN;
            end
         end
         ST_RUN: begin
            if (div_stat.done && out_free) begin
               load      = 1'b1;
               result_in = formatted;
               state_in  = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end

      clock_hz_in = clock_hz_ff;
      if (csr_bus.valid) begin
         clock_hz_in = csr_bus.source_clock_hz;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         clock_hz_ff  <= CLOCK_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         clock_hz_ff  <= clock_hz_in;
      end
      baud_zero_ff <= baud_zero_in;
      result_ff    <= result_in;
   end

   assign req_bus.ready             = (state_ff == ST_IDLE);
   assign rsp_bus.valid             = rsp_valid_ff;
   assign rsp_bus.prescaler         = result_ff.prescaler;
   assign rsp_bus.first_modulation  = result_ff.first_modulation;
   assign rsp_bus.oversample_on     = result_ff.oversample_on;
   assign rsp_bus.second_modulation = result_ff.second_modulation;
   assign rsp_bus.status            = result_ff.status;

   a_busy_in_run: assert property (@(posedge clock) disable iff (reset)
      div_stat.busy |-> (state_ff == ST_RUN))
      else $error("divider busy outside run state");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> div_stat.busy)
      else $error("accepted request did not start the divider");

   a_load_valid: assert property (@(posedge clock) disable iff (reset)
      load |=> (rsp_valid_ff && (state_ff == ST_IDLE)))
      else $error("finished result not presented");

   a_zero_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (result_ff.status == STATUS_BAUD_ZERO))
         |-> (result_ff.prescaler == '0 && !result_ff.oversample_on))
      else $error("zero baud rate result carries nonzero fields");

   a_sat_oversample: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (result_ff.status == STATUS_SATURATED))
         |-> (result_ff.oversample_on && result_ff.prescaler == PRESCALER_MAX))
      else $error("saturated prescaler without oversampling");

endmodule

/* test/uart_baud_divisor_calc_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// uart_baud_divisor_calc_tb
// Self-checking bench for the baud divisor calculator. Requests are fed
// through a valid/ready driver and every response is checked field by field
// against a behavioral prediction of the 32.16 divide, the oversampling split,
// the prescaler saturation and the fraction-to-pattern lookup. The source
// clock setting is changed between drained phases, including zero, one and
// the full 32-bit value. Both channels idle in random bursts, and the response
// side holds off once for a long stretch to back the block up.
// ----------------------------------------------------------------------------
module uart_baud_divisor_calc_tb;
   import ubdc_pkg::*;

   localparam logic [15:0] STEP_EDGE [36] = '{
      16'd0,     16'd3466,  16'd4685,  16'd5472,  16'd6560,  16'd8205,
      16'd9371,  16'd10944, 16'd14070, 16'd14575, 16'd16403, 16'd19660,
      16'd21856, 16'd23429, 16'd24595, 16'd26234, 16'd28088, 16'd28691,
      16'd32781, 16'd37453, 16'd39341, 16'd40986, 16'd42152, 16'd43692,
      16'd45881, 16'd46838, 16'd49171, 16'd51517, 16'd52455, 16'd54611,
      16'd55469, 16'd56177, 16'd57350, 16'd59008, 16'd60096, 16'd60869
   };

   localparam logic [7:0] STEP_BYTE [36] = '{
      8'h00, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10,
      8'h20, 8'h11, 8'h21, 8'h22, 8'h44, 8'h25,
      8'h49, 8'h4A, 8'h52, 8'h92, 8'h53, 8'h55,
      8'hAA, 8'h6B, 8'hAD, 8'hB5, 8'hB6, 8'hD6,
      8'hB7, 8'hBB, 8'hDD, 8'hED, 8'hEE, 8'hBF,
      8'hDF, 8'hEF, 8'hF7, 8'hFB, 8'hFD, 8'hFE
   };

   localparam logic [31:0] COMMON_RATES [10] = '{
      32'd300, 32'd1200, 32'd2400, 32'd4800, 32'd9600,
      32'd19200, 32'd38400, 32'd57600, 32'd115200, 32'd921600
   };

   localparam int LONG_HOLD    = 300;
   localparam int HOLD_AT_RESP = 40;

   logic clock;
   logic reset;

   ubdc_csr_if csr_bus ();
   ubdc_req_if req_bus ();
   ubdc_rsp_if rsp_bus ();

   uart_baud_divisor_calc dut (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   logic [31:0]     clock_hz;
   logic [31:0]     baud_pending [$];
   ubdc_result_type divisor_expected [$];
   ubdc_result_type next_want;
   logic            relaxed;
   int              send_gap;
   int              recv_gap;
   int              hold_left;
   logic            hold_done;
   int              mismatches;
   int              responses_seen;
   int              zero_seen;
   int              saturated_seen;
   int              oversampled_seen;
   int              settings_used;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic ubdc_result_type predict_divisor(input logic [31:0] baud);
      ubdc_result_type r;
      logic [47:0]     ratio;
      logic [31:0]     whole;
      logic [15:0]     frac;
      r = '0;
      if (baud == 32'd0) begin
         r.status = STATUS_BAUD_ZERO;
      end else begin
         ratio = {clock_hz, 16'h0000} / {16'h0000, baud};
         whole = ratio[47:16];
         frac  = ratio[15:0];
         if (whole > 32'd16) begin
            r.oversample_on    = 1'b1;
            r.first_modulation = whole[3:0];
            if (whole[31:4] > 28'd65535) begin
               r.prescaler = 16'hFFFF;
               r.status    = STATUS_SATURATED;
            end else begin
               r.prescaler = whole[19:4];
            end
         end else begin
            r.prescaler = whole[15:0];
         end
         for (int i = 0; i < 36; i++) begin
            if (STEP_EDGE[i] <= frac) r.second_modulation = STEP_BYTE[i];
         end
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (mismatches < 40)
         $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
      mismatches++;
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         send_gap      <= 0;
      end else begin
         if (req_bus.valid && req_bus.ready)
            divisor_expected.push_back(predict_divisor(req_bus.baud_rate));
         if (!req_bus.valid || req_bus.ready) begin
            if (send_gap > 0) begin
               send_gap      <= send_gap - 1;
               req_bus.valid <= 1'b0;
            end else if (baud_pending.size() > 0) begin
               req_bus.valid     <= 1'b1;
               req_bus.baud_rate <= baud_pending.pop_front();
               if (!relaxed && $urandom_range(0, 5) == 0) send_gap <= $urandom_range(1, 16);
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         recv_gap      <= 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            responses_seen <= responses_seen + 1;
            if (divisor_expected.size() == 0) begin
               report_mismatch("transaction with nothing pending", rsp_bus.prescaler, 0);
            end else begin
               next_want = divisor_expected.pop_front();
               if (rsp_bus.prescaler !== next_want.prescaler)
                  report_mismatch("prescaler", rsp_bus.prescaler, next_want.prescaler);
               if (rsp_bus.first_modulation !== next_want.first_modulation)
                  report_mismatch("first_modulation", rsp_bus.first_modulation,
                                  next_want.first_modulation);
               if (rsp_bus.oversample_on !== next_want.oversample_on)
                  report_mismatch("oversample_on", rsp_bus.oversample_on,
                                  next_want.oversample_on);
               if (rsp_bus.second_modulation !== next_want.second_modulation)
                  report_mismatch("second_modulation", rsp_bus.second_modulation,
                                  next_want.second_modulation);
               if (rsp_bus.status !== next_want.status)
                  report_mismatch("status", rsp_bus.status, next_want.status);
               if (next_want.status == STATUS_BAUD_ZERO) zero_seen++;
               if (next_want.status == STATUS_SATURATED) saturated_seen++;
               if (next_want.oversample_on) oversampled_seen++;
            end
         end
         if (recv_gap > 0) begin
            recv_gap      <= recv_gap - 1;
            rsp_bus.ready <= 1'b0;
         end else if (!relaxed && $urandom_range(0, 6) == 0) begin
            recv_gap      <= $urandom_range(0, 15);
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= (hold_left == 0);
         end
      end
   end

   // long hold-off on the response side
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end else if (!hold_done && responses_seen == HOLD_AT_RESP) begin
         hold_left <= LONG_HOLD;
         hold_done <= 1'b1;
      end
   end

   task automatic apply_clock(input logic [31:0] hz);
      @(posedge clock);
      csr_bus.valid           <= 1'b1;
      csr_bus.source_clock_hz <= hz;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      csr_bus.valid <= 1'b0;
      clock_hz = hz;
      settings_used++;
   endtask

   task automatic add_random(input int count);
      logic [31:0] rate;
      int          div;
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(0, 6))
            0: rate = COMMON_RATES[$urandom_range(0, 9)];
            1: rate = $urandom_range(1, 255);
            2: rate = $urandom;
            3: begin
               // land near the oversampling boundary
               div  = $urandom_range(15, 18);
               rate = clock_hz / div + $urandom_range(0, 2);
            end
            4: rate = (clock_hz == 0) ? $urandom : $urandom_range(1, clock_hz);
            5: rate = clock_hz >> $urandom_range(0, 31);
            default: rate = ($urandom_range(0, 2) == 0) ? 32'd0 : $urandom_range(256, 4000000);
         endcase
         baud_pending.push_back(rate);
      end
   endtask

   task automatic wait_drained;
      do @(negedge clock);
      while (baud_pending.size() != 0 || req_bus.valid || divisor_expected.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   initial begin
      reset                   = 1'b1;
      relaxed                 = 1'b0;
      clock_hz                = CLOCK_RESET;
      csr_bus.valid           = 1'b0;
      csr_bus.source_clock_hz = '0;
      req_bus.valid           = 1'b0;
      req_bus.baud_rate       = '0;
      rsp_bus.ready           = 1'b0;
      mismatches              = 0;
      responses_seen          = 0;
      zero_seen               = 0;
      saturated_seen          = 0;
      oversampled_seen        = 0;
      settings_used           = 1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset clock setting: zero rate, saturation edge, oversampling edge
      foreach (COMMON_RATES[i]) baud_pending.push_back(COMMON_RATES[i]);
      baud_pending.push_back(32'd0);
      baud_pending.push_back(32'd1);
      baud_pending.push_back(32'd2);
      baud_pending.push_back(32'd3);
      baud_pending.push_back(32'd187500);
      baud_pending.push_back(32'd176470);
      baud_pending.push_back(32'd176471);
      baud_pending.push_back(32'd3000000);
      baud_pending.push_back(32'd3000001);
      baud_pending.push_back(32'd6000000);
      baud_pending.push_back(32'h8000_0000);
      baud_pending.push_back(32'hFFFF_FFFF);
      add_random(70);
      wait_drained();

      apply_clock(32'd1);
      baud_pending.push_back(32'd1);
      add_random(55);
      wait_drained();

      apply_clock(32'hFFFF_FFFF);
      baud_pending.push_back(32'd1);
      baud_pending.push_back(32'hFFFF_FFFF);
      add_random(55);
      wait_drained();

      apply_clock(32'd0);
      baud_pending.push_back(32'd0);
      baud_pending.push_back(32'd1);
      baud_pending.push_back(32'hFFFF_FFFF);
      add_random(40);
      wait_drained();

      apply_clock(32'd48000000);
      add_random(55);
      wait_drained();

      apply_clock($urandom);
      add_random(55);
      wait_drained();

      relaxed = 1'b1;
      apply_clock(32'd16000000);
      add_random(55);
      wait_drained();

      repeat (60) @(negedge clock);
      $display("Checked %0d responses across %0d clock settings.",
               responses_seen, settings_used);
      $display("Zero-rate: %0d, saturated: %0d, oversampled: %0d, mismatches: %0d.",
               zero_seen, saturated_seen, oversampled_seen, mismatches);
      if (mismatches == 0 && divisor_expected.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Timeout with %0d responses still pending.", divisor_expected.size());
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

/* filelist.f */
hw/rtl/ubdc_pkg.sv
hw/rtl/ubdc_ifs.sv
hw/rtl/ubdc_divider.sv
hw/rtl/ubdc_format.sv
hw/rtl/uart_baud_divisor_calc.sv
test/uart_baud_divisor_calc_tb.sv
